// ----- sv/rfdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis table package
// Shared sizes, codes, the controller state type and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfdt_pkg;

   localparam int MAX_NODES = 8;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int DEPTH     = MAX_NODES * MAX_NODES;
   localparam int CSR_W     = 4;
   localparam int CMP_W     = (CSR_W > CNT_W) ? CSR_W : CNT_W;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CSR_W-1:0]  csr_type;
   typedef logic [1:0]        opcode_type;
   typedef logic signed [1:0] view_type;

   localparam opcode_type OP_TEST    = 2'd0;
   localparam opcode_type OP_FAIL    = 2'd1;
   localparam opcode_type OP_RECOVER = 2'd2;

   localparam view_type VIEW_UNKNOWN = 2'sb11;
   localparam view_type VIEW_OK      = 2'sb00;
   localparam view_type VIEW_SUSPECT = 2'sb01;
   localparam view_type VIEW_INVALID = 2'sb10;

   localparam csr_type COUNT_RESET = csr_type'(8);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_WALK = 6'b000010,
      S_CRD  = 6'b000100,
      S_CWR  = 6'b001000,
      S_MARK = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic suspect;
      logic walk_done;
      logic copy_read;
      logic copy_write;
      logic mark;
      logic emit_read;
   } cmd_type;

   typedef struct packed {
      logic test_go;
      logic walk_stop;
      logic found_is_tester;
      logic copy_none;
      logic pos_last;
      logic emit_last;
   } status_type;

   function automatic node_type next_node(node_type p, count_type n);
      count_type s;
      s = count_type'(p) + count_type'(1);
      return (s >= n) ? '0 : s[NODE_W-1:0];
   endfunction

endpackage

// ----- sv/rfdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis controller
// Sequences a test: the walk over failed nodes, the copy of the found node's
// view, the mark of the found node and the read-out of the tester's row.
// ----------------------------------------------------------------------------
module rfdt_ctrl
   import rfdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.test_go) begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (!status.walk_stop) begin
               cmd.suspect = 1'b1;
            end else begin
               cmd.walk_done = 1'b1;
               if (status.found_is_tester || status.copy_none) begin
                  state_in = S_MARK;
               end else begin
                  state_in = S_CRD;
               end
            end
         end
         S_CRD: begin
            cmd.copy_read = 1'b1;
            state_in      = S_CWR;
         end
         S_CWR: begin
            cmd.copy_write = 1'b1;
            state_in       = status.pos_last ? S_MARK : S_CRD;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_read = 1'b1;
            if (status.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- sv/rfdt_datapath.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis datapath
// Holds the ring size register, the failed flags, the view table memory with
// its valid bits, the walk pointers and the registered result word.
// ----------------------------------------------------------------------------
module rfdt_datapath
   import rfdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_node,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output logic [2:0] rsp_entry_index,
   output logic signed [1:0] rsp_entry_value,
   output logic [2:0] rsp_tested_node,
   output logic       rsp_tester_alone,
   output logic       rsp_last
);

   csr_type              node_count_ff;
   logic [CMP_W-1:0]     count_wide;
   count_type            ring_size;
   logic                 in_ring;
   logic [MAX_NODES-1:0] failed_ff;
   node_type             tester_ff;
   node_type             found_ff;
   node_type             pos_ff;
   node_type             idx_ff;
   logic                 alone_ff;
   logic [1:0]           mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [1:0]           rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_diag_ff;
   view_type             rd_value;
   logic                 we;
   addr_type             waddr;
   view_type             wdata;
   logic                 re;
   addr_type             raddr;
   logic                 strobe_ff;
   node_type             out_index_ff;
   logic                 out_last_ff;

   always_comb begin
      count_wide = CMP_W'(node_count_ff);
      if (count_wide < CMP_W'(2)) begin
         ring_size = count_type'(2);
      end else if (count_wide > CMP_W'(MAX_NODES)) begin
         ring_size = count_type'(MAX_NODES);
      end else begin
         ring_size = count_wide[CNT_W-1:0];
      end
   end

   assign in_ring = (count_type'(req_node) < ring_size);

   always_comb begin
      status.test_go         = in_ring && (req_operation == OP_TEST) && !failed_ff[req_node];
      status.walk_stop       = !failed_ff[found_ff] || (found_ff == tester_ff);
      status.found_is_tester = (found_ff == tester_ff);
      status.copy_none       = (next_node(found_ff, ring_size) == tester_ff);
      status.pos_last        = (next_node(pos_ff, ring_size) == tester_ff);
      status.emit_last       = ((count_type'(idx_ff) + count_type'(1)) == ring_size);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
         failed_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            node_count_ff <= csr_write_data;
         end
         if (cmd.load && in_ring) begin
            if (req_operation == OP_FAIL) begin
               failed_ff[req_node] <= 1'b1;
            end else if (req_operation == OP_RECOVER) begin
               failed_ff[req_node] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tester_ff <= req_node;
         found_ff  <= next_node(req_node, ring_size);
      end
      if (cmd.suspect) begin
         found_ff <= next_node(found_ff, ring_size);
      end
      if (cmd.walk_done) begin
         pos_ff   <= next_node(found_ff, ring_size);
         alone_ff <= (found_ff == tester_ff);
      end
      if (cmd.copy_write) begin
         pos_ff <= next_node(pos_ff, ring_size);
      end
      if (cmd.mark) begin
         idx_ff <= '0;
      end
      if (cmd.emit_read) begin
         idx_ff <= idx_ff + node_type'(1);
      end
   end

   assign rd_value = rd_valid_ff ? view_type'(rd_data_ff)
                                 : (rd_diag_ff ? VIEW_OK : VIEW_UNKNOWN);

   always_comb begin
      we    = cmd.suspect || cmd.copy_write || cmd.mark;
      waddr = {tester_ff, cmd.copy_write ? pos_ff : found_ff};
      if (cmd.suspect) begin
         wdata = VIEW_SUSPECT;
      end else if (cmd.copy_write) begin
         wdata = rd_value;
      end else begin
         wdata = VIEW_OK;
      end
      re    = cmd.copy_read || cmd.emit_read;
      raddr = cmd.copy_read ? {found_ff, pos_ff} : {tester_ff, idx_ff};
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff  <= mem[raddr];
         rd_valid_ff <= valid_ff[raddr];
         rd_diag_ff  <= (raddr[ADDR_W-1:NODE_W] == raddr[NODE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         strobe_ff <= cmd.emit_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_read) begin
         out_index_ff <= idx_ff;
         out_last_ff  <= status.emit_last;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_entry_index  = out_index_ff;
   assign rsp_entry_value  = rd_value;
   assign rsp_tested_node  = found_ff;
   assign rsp_tester_alone = alone_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ----- sv/ring_fault_diagnosis_table.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis table
// Failed flags and per-node view table of an adaptive diagnosis ring.
// ----------------------------------------------------------------------------
// An event is taken on req_operation and req_node at a clock edge where start
// is high and busy is low. Fault and recovery events, events for nodes outside
// the ring, the unused operation code and a test by a failed node are absorbed
// at that edge and busy stays low.
// A test by a fault-free node of a ring of n nodes raises busy. The walk marks
// each suspected node in turn and then stops, the copy reads and then writes
// each copied entry through the view memory, then comes the mark, and the
// read-out goes through the tester's row entry by entry.
// The next event can be taken once busy is low again.
// The row comes out as n words, one per cycle, each marked by rsp_strobe for
// exactly one cycle, the first in the cycle after read-out begins; rsp_last
// flags the final word, which shows in the first cycle in which busy is low.
// The receiver cannot hold words off and must take each one as it appears.
// csr_write_enable writes the ring size; write it only while the block idles.
// A synchronous reset marks every node fault-free, sets the ring size to eight
// and makes every view entry read as unknown, a node's own entry as fault-free.
// ----------------------------------------------------------------------------
module ring_fault_diagnosis_table
   import rfdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_node,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   output logic       rsp_strobe,
   output logic [2:0] rsp_entry_index,
   output logic signed [1:0] rsp_entry_value,
   output logic [2:0] rsp_tested_node,
   output logic       rsp_tester_alone,
   output logic       rsp_last
);

   cmd_type    cmd;
   status_type status;

   rfdt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rfdt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_node         (req_node),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_tested_node  (rsp_tested_node),
      .rsp_tester_alone (rsp_tester_alone),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- sv/rfdt_checker.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis checker
// Port-level checks on the word stream of the diagnosis table.
// ----------------------------------------------------------------------------
module rfdt_checker
   import rfdt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [2:0] rsp_entry_index,
   input logic signed [1:0] rsp_entry_value,
   input logic [2:0] rsp_tested_node,
   input logic       rsp_last
);

   // A row is sent without gaps, in index order, about one tested node.
   a_row_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("row of words broken off before its last word");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=>
         (rsp_entry_index == ($past(rsp_entry_index) + 3'd1)))
      else $error("view entries out of order");

   a_row_tested: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> $stable(rsp_tested_node))
      else $error("tested node changed within a row");

   a_no_word_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("word sent right after an event was taken");

   a_value_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_value != VIEW_INVALID))
      else $error("view entry carries an undefined code");

endmodule

bind ring_fault_diagnosis_table rfdt_checker u_rfdt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_entry_index (rsp_entry_index),
   .rsp_entry_value (rsp_entry_value),
   .rsp_tested_node (rsp_tested_node),
   .rsp_last        (rsp_last)
);

// ----- tb/tb_ring_fault_diagnosis_table.sv -----
// ----------------------------------------------------------------------------
// Ring fault diagnosis table testbench
// Drives fault, recovery, test and ignored events into the block under several
// ring sizes, both in and out of the legal range. A local model of the failed
// flags and view table predicts every row word, and a monitor checks each
// strobed word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ring_fault_diagnosis_table;
   import rfdt_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 25;
   localparam opcode_type OP_UNUSED = 2'd3;

   typedef struct packed {
      opcode_type op;
      node_type   node;
   } diag_event_type;

   typedef struct packed {
      node_type entry_index;
      view_type entry_value;
      node_type tested_node;
      logic     tester_alone;
      logic     last;
   } row_word_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       start            = 1'b0;
   logic       busy;
   logic [1:0] req_operation    = '0;
   logic [2:0] req_node         = '0;
   logic       csr_write_enable = 1'b0;
   logic [3:0] csr_write_data   = '0;
   logic       rsp_strobe;
   logic [2:0] rsp_entry_index;
   logic signed [1:0] rsp_entry_value;
   logic [2:0] rsp_tested_node;
   logic       rsp_tester_alone;
   logic       rsp_last;

   diag_event_type pending_events[$];
   row_word_type   expected_row[$];
   int             mismatches  = 0;
   int             stall_cycles = 0;
   int             gap_left    = 0;
   bit             quiet       = 1'b0;

   csr_type  model_count;
   logic     model_failed [MAX_NODES];
   view_type model_view   [MAX_NODES][MAX_NODES];

   ring_fault_diagnosis_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_node         (req_node),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_tested_node  (rsp_tested_node),
      .rsp_tester_alone (rsp_tester_alone),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int ring_size(csr_type count);
      if (count < 2) return 2;
      if (count > MAX_NODES) return MAX_NODES;
      return int'(count);
   endfunction

   function automatic int next_pos(int p, int n);
      return (p + 1 >= n) ? 0 : p + 1;
   endfunction

   task automatic reset_model();
      model_count = COUNT_RESET;
      for (int i = 0; i < MAX_NODES; i++) begin
         model_failed[i] = 1'b0;
         for (int j = 0; j < MAX_NODES; j++) begin
            model_view[i][j] = VIEW_UNKNOWN;
         end
         model_view[i][i] = VIEW_OK;
      end
   endtask

   task automatic diagnose_event(diag_event_type ev);
      int           n;
      int           t;
      int           found;
      bit           alone;
      row_word_type w;
      n = ring_size(model_count);
      t = int'(ev.node);
      if (t >= n) return;
      case (ev.op)
         OP_FAIL: begin
            model_failed[t] = 1'b1;
         end
         OP_RECOVER: begin
            model_failed[t] = 1'b0;
         end
         OP_TEST: begin
            if (!model_failed[t]) begin
               found = next_pos(t, n);
               while (model_failed[found] && found != t) begin
                  model_view[t][found] = VIEW_SUSPECT;
                  found = next_pos(found, n);
               end
               alone = (found == t);
               if (!alone) begin
                  for (int p = next_pos(found, n); p != t; p = next_pos(p, n)) begin
                     model_view[t][p] = model_view[found][p];
                  end
               end
               model_view[t][found] = VIEW_OK;
               for (int j = 0; j < n; j++) begin
                  w.entry_index  = node_type'(j);
                  w.entry_value  = model_view[t][j];
                  w.tested_node  = node_type'(found);
                  w.tester_alone = alone;
                  w.last         = (j + 1 == n);
                  expected_row.push_back(w);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // Driver: presents the oldest pending event and holds it until accepted.
   always @(posedge clock) begin : driver
      logic present;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         present = start;
         if (start && !busy) begin
            pending_events.delete(0);
            present = 1'b0;
         end
         if (!present) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_events.size() != 0 && !quiet &&
                         $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 3);
            end else if (pending_events.size() != 0) begin
               present = 1'b1;
               req_operation <= pending_events[0].op;
               req_node      <= pending_events[0].node;
            end
         end
         start <= present;
      end
   end

   // Monitor: checks row words, predicts on acceptance and tracks the ring size.
   always @(posedge clock) begin : monitor
      row_word_type   got;
      row_word_type   want;
      diag_event_type ev;
      if (reset) begin
         reset_model();
         stall_cycles = 0;
      end else begin
         if (rsp_strobe) begin
            got = '{rsp_entry_index, rsp_entry_value, rsp_tested_node,
                    rsp_tester_alone, rsp_last};
            if (expected_row.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word: index %0d value %0d tested %0d alone %0b last %0b",
                        $time, got.entry_index, got.entry_value, got.tested_node,
                        got.tester_alone, got.last);
            end else begin
               want = expected_row.pop_front();
               if (got != want) begin
                  mismatches++;
                  $display("%0t: expected index %0d value %0d tested %0d alone %0b last %0b",
                           $time, want.entry_index, want.entry_value, want.tested_node,
                           want.tester_alone, want.last);
                  $display("%0t: actual   index %0d value %0d tested %0d alone %0b last %0b",
                           $time, got.entry_index, got.entry_value, got.tested_node,
                           got.tester_alone, got.last);
               end
            end
         end
         if (start && !busy) begin
            ev = '{req_operation, req_node};
            diagnose_event(ev);
         end
         if (csr_write_enable) begin
            model_count = csr_write_data;
         end
         if (rsp_strobe || (start && !busy) || csr_write_enable) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic queue_event(opcode_type op, int node);
      pending_events.push_back('{op, node_type'(node)});
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_events.size() != 0 || start || busy || expected_row.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_node_count(csr_type value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      csr_type        counts [RANDOM_PHASES];
      diag_event_type ev;
      int             counted;
      int             n;
      int             r;
      counts = '{4'd2, 4'd15, 4'd5, 4'd0, 4'd3, 4'd9, 4'd1, 4'd7, 4'd6, 4'd8};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_event(OP_TEST, 0);
      queue_event(OP_FAIL, 1);
      queue_event(OP_FAIL, 1);
      queue_event(OP_FAIL, 2);
      queue_event(OP_TEST, 0);
      queue_event(OP_TEST, 3);
      queue_event(OP_TEST, 1);
      queue_event(OP_RECOVER, 2);
      queue_event(OP_RECOVER, 2);
      queue_event(OP_UNUSED, 7);
      queue_event(OP_TEST, 7);
      for (int i = 0; i < MAX_NODES; i++) begin
         if (i != 4) queue_event(OP_FAIL, i);
      end
      queue_event(OP_TEST, 4);
      queue_event(OP_RECOVER, 6);
      queue_event(OP_TEST, 4);
      queue_event(OP_TEST, 6);
      drain();

      write_node_count(4'd3);
      queue_event(OP_TEST, 5);
      queue_event(OP_FAIL, 7);
      queue_event(OP_TEST, 2);
      queue_event(OP_RECOVER, 0);
      queue_event(OP_TEST, 0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_node_count(counts[ph]);
         quiet   = (ph == RANDOM_PHASES - 1);
         n       = ring_size(counts[ph]);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = $urandom_range(0, 19);
            ev.op   = (r < 10) ? OP_TEST : (r < 14) ? OP_FAIL :
                      (r < 18) ? OP_RECOVER : OP_UNUSED;
            if ($urandom_range(0, 7) == 0) begin
               ev.node = node_type'($urandom_range(0, MAX_NODES - 1));
            end else begin
               ev.node = node_type'($urandom_range(0, n - 1));
            end
            pending_events.push_back(ev);
            counted++;
         end
         drain();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_row.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
